FILE: rtl/fhst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhst_pkg
// Shared types and constants of the per-host flow statistics table.
// ----------------------------------------------------------------------------
package fhst_pkg;

	localparam int HOST_ENTRIES_DEF = 64;
	localparam int FLOW_CLASSES     = 4;
	localparam int CLASS_W          = 2;
	localparam int LEN_W            = 16;
	localparam int BYTE_W           = 48;
	localparam int PKT_W            = 32;
	localparam int SLOT_OUT_W       = 6;
	localparam int FIFO_DEPTH       = 2;   // power of two

	localparam logic [7:0]        TCP_PROTO = 8'd6;
	localparam logic [BYTE_W-1:0] BYTE_MAX  = {BYTE_W{1'b1}};
	localparam logic [PKT_W-1:0]  PKT_MAX   = {PKT_W{1'b1}};

	// classified word, front to back (slot travels beside it)
	typedef struct packed {
		logic [CLASS_W-1:0] flow_class;
		logic               new_host;
		logic               table_full;
		logic [LEN_W-1:0]   ip_length;
	} fhst_cmd_t;

	// result word
	typedef struct packed {
		logic [SLOT_OUT_W-1:0] host_slot;
		logic [CLASS_W-1:0]    flow_class;
		logic                  new_host;
		logic                  table_full;
		logic [BYTE_W-1:0]     byte_total_out;
		logic [PKT_W-1:0]      packet_total_out;
	} fhst_res_t;

endpackage
`default_nettype wire

FILE: rtl/host_flow_stats_table.sv
`default_nettype none
// Flow: the front register takes the word, then the back sequencer steps
//   through pop, read, update and done for a known host; pop, init (the
//   slot's four counter words written: the packet's class seeded, the
//   rest zeroed) and done for a new host; pop and done for a drop. The
//   back takes one word at a time through the single-port counter RAM.
// Reset: arst_n clears the host count, queues and sequencer; counter words
//   are written when their slot is allocated, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// host_flow_stats_table
// Per-host TCP/other up/down packet and byte counters with bounded host table.
// ----------------------------------------------------------------------------
module host_flow_stats_table import fhst_pkg::*; #(
	parameter int HOST_ENTRIES = HOST_ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input word queue side
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [31:0]           host_ip,
	input  wire logic                  is_upstream,
	input  wire logic [7:0]            protocol,
	input  wire logic [LEN_W-1:0]      ip_length,
	// result word queue side
	output logic                       empty,
	input  wire logic                  pop,
	output logic [SLOT_OUT_W-1:0]      host_slot,
	output logic [CLASS_W-1:0]         flow_class,
	output logic                       new_host,
	output logic                       table_full,
	output logic [BYTE_W-1:0]          byte_total_out,
	output logic [PKT_W-1:0]           packet_total_out
);

	localparam int SLOT_W  = $clog2(HOST_ENTRIES);
	localparam int CMD_W   = SLOT_W + $bits(fhst_cmd_t);
	localparam int RES_W   = $bits(fhst_res_t);

	// front -> command queue
	logic              f_push;
	logic              q_full;
	logic [SLOT_W-1:0] f_slot;
	fhst_cmd_t         f_cmd;

	// command queue -> back
	logic              q_empty;
	logic              b_pop;
	logic [CMD_W-1:0]  q_rdata;
	logic [SLOT_W-1:0] b_slot;
	fhst_cmd_t         b_cmd;

	// back -> result queue
	logic              r_push;
	logic              r_full;
	fhst_res_t         b_res;
	fhst_res_t         r_word;

	// Front: registers the input word, matches the host against every live
	// slot combinationally, allocates the next slot for a new host, and classes
	// the packet. The next word may load while this one is handed off.
	fhst_front #(
		.HOST_ENTRIES (HOST_ENTRIES),
		.SLOT_W       (SLOT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.host_ip     (host_ip),
		.is_upstream (is_upstream),
		.protocol    (protocol),
		.ip_length   (ip_length),
		.cmd_push    (f_push),
		.cmd_full    (q_full),
		.cmd_slot    (f_slot),
		.cmd         (f_cmd)
	);

	// Command queue decouples lookup from the counter RAM sequence.
	fhst_fifo #(
		.W (CMD_W)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  ({f_slot, f_cmd}),
		.full   (q_full),
		.pop    (b_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign b_slot = q_rdata[CMD_W-1 -: SLOT_W];
	assign b_cmd  = q_rdata[$bits(fhst_cmd_t)-1:0];

	// Back: counter RAM indexed by {slot, class}; saturating update.
	fhst_back #(
		.HOST_ENTRIES (HOST_ENTRIES),
		.SLOT_W       (SLOT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (q_empty),
		.cmd_pop   (b_pop),
		.cmd_slot  (b_slot),
		.cmd       (b_cmd),
		.res_push  (r_push),
		.res_full  (r_full),
		.res       (b_res)
	);

	// Result queue: a finished word can wait while the back starts the next.
	fhst_fifo #(
		.W (RES_W)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (r_push),
		.wdata  (b_res),
		.full   (r_full),
		.pop    (pop),
		.rdata  (r_word),
		.empty  (empty)
	);

	assign host_slot        = r_word.host_slot;
	assign flow_class       = r_word.flow_class;
	assign new_host         = r_word.new_host;
	assign table_full       = r_word.table_full;
	assign byte_total_out   = r_word.byte_total_out;
	assign packet_total_out = r_word.packet_total_out;

endmodule
`default_nettype wire

FILE: rtl/fhst_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhst_fifo
// Small synchronous queue of FIFO_DEPTH words.
// ----------------------------------------------------------------------------
module fhst_fifo import fhst_pkg::*; #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [W-1:0]  mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
			else if (!do_push && do_pop) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule
`default_nettype wire

FILE: rtl/fhst_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhst_front
// Input register, parallel host match, in-order slot allocation, classing.
// ----------------------------------------------------------------------------
module fhst_front import fhst_pkg::*; #(
	parameter int HOST_ENTRIES = HOST_ENTRIES_DEF,
	parameter int SLOT_W       = $clog2(HOST_ENTRIES)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [31:0]       host_ip,
	input  wire logic              is_upstream,
	input  wire logic [7:0]        protocol,
	input  wire logic [LEN_W-1:0]  ip_length,
	output logic                   cmd_push,
	input  wire logic              cmd_full,
	output logic [SLOT_W-1:0]      cmd_slot,
	output fhst_cmd_t              cmd
);

	localparam int CNT_W = $clog2(HOST_ENTRIES + 1);

	logic                 valid_s1;
	logic [31:0]          ip_s1;
	logic                 up_s1;
	logic [7:0]           proto_s1;
	logic [LEN_W-1:0]     len_s1;

	logic [31:0]          addr_q [HOST_ENTRIES];
	logic [CNT_W-1:0]     count_q;

	logic                 hit;
	logic [SLOT_W-1:0]    hit_slot;
	logic                 room;
	logic                 alloc;
	logic                 accept;

	assign full     = valid_s1 && cmd_full;
	assign accept   = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;

	// slots fill in order, so slot i is live when i < count_q; live
	// addresses are unique, so an OR of the matching indexes is the encoder
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int i = 0; i < HOST_ENTRIES; i++) begin
			if ((CNT_W'(i) < count_q) && (addr_q[i] == ip_s1)) begin
				hit      = 1'b1;
				hit_slot = hit_slot | SLOT_W'(i);
			end
		end
	end

	assign room  = (count_q != CNT_W'(HOST_ENTRIES));
	assign alloc = cmd_push && !hit && room;

	always_comb begin
		cmd.flow_class = {(proto_s1 == TCP_PROTO), !up_s1};
		cmd.ip_length  = len_s1;
		cmd.new_host   = !hit && room;
		cmd.table_full = !hit && !room;
		if (hit)       cmd_slot = hit_slot;
		else if (room) cmd_slot = count_q[SLOT_W-1:0];
		else           cmd_slot = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			count_q  <= '0;
		end else begin
			if (accept)        valid_s1 <= 1'b1;
			else if (cmd_push) valid_s1 <= 1'b0;
			if (alloc) count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ip_s1    <= host_ip;
			up_s1    <= is_upstream;
			proto_s1 <= protocol;
			len_s1   <= ip_length;
		end
		if (alloc) addr_q[count_q[SLOT_W-1:0]] <= ip_s1;
	end

endmodule
`default_nettype wire

FILE: rtl/fhst_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhst_back
// Counter RAM sequencer: seed/zero new hosts, read-modify-write known hosts.
// ----------------------------------------------------------------------------
module fhst_back import fhst_pkg::*; #(
	parameter int HOST_ENTRIES = HOST_ENTRIES_DEF,
	parameter int SLOT_W       = $clog2(HOST_ENTRIES)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_empty,
	output logic                   cmd_pop,
	input  wire logic [SLOT_W-1:0] cmd_slot,
	input  wire fhst_cmd_t         cmd,
	output logic                   res_push,
	input  wire logic              res_full,
	output fhst_res_t              res
);

	localparam int MEM_DEPTH = HOST_ENTRIES * FLOW_CLASSES;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int DW        = BYTE_W + PKT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]          state_q;
	logic [CLASS_W-1:0]  k_q;
	logic [SLOT_W-1:0]   slot_q;
	fhst_cmd_t           cmd_q;
	fhst_res_t           res_q;

	logic [DW-1:0]       mem [MEM_DEPTH];
	logic [DW-1:0]       rd_q;

	logic                mem_we;
	logic [AW-1:0]       mem_addr;
	logic [DW-1:0]       mem_wdata;

	logic [BYTE_W-1:0]   old_b;
	logic [PKT_W-1:0]    old_p;
	logic [BYTE_W:0]     sum_b;
	logic [BYTE_W-1:0]   new_b;
	logic [PKT_W-1:0]    new_p;

	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
	assign res_push = (state_q == ST_DONE) && !res_full;
	assign res      = res_q;

	assign old_b = rd_q[DW-1:PKT_W];
	assign old_p = rd_q[PKT_W-1:0];
	assign sum_b = {1'b0, old_b} + (BYTE_W+1)'(cmd_q.ip_length);
	assign new_b = sum_b[BYTE_W] ? BYTE_MAX : sum_b[BYTE_W-1:0];
	assign new_p = (old_p == PKT_MAX) ? old_p : old_p + PKT_W'(1);

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = {slot_q, cmd_q.flow_class};
		mem_wdata = {new_b, new_p};
		case (state_q)
			ST_INIT: begin
				mem_we   = 1'b1;
				mem_addr = {slot_q, k_q};
				if (k_q == cmd_q.flow_class)
					mem_wdata = {BYTE_W'(cmd_q.ip_length), PKT_W'(1)};
				else
					mem_wdata = '0;
			end
			ST_UPD:  mem_we = 1'b1;
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (state_q == ST_RD) rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (!cmd_empty) begin
						if (cmd.table_full)    state_q <= ST_DONE;
						else if (cmd.new_host) state_q <= ST_INIT;
						else                   state_q <= ST_RD;
					end
				end
				ST_INIT: begin
					k_q <= k_q + CLASS_W'(1);
					if (k_q == CLASS_W'(FLOW_CLASSES - 1)) state_q <= ST_DONE;
				end
				ST_RD:   state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_DONE;
				ST_DONE: if (!res_full) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					slot_q <= cmd_slot;
					cmd_q  <= cmd;
					res_q.host_slot        <= SLOT_OUT_W'(cmd_slot);
					res_q.flow_class       <= cmd.flow_class;
					res_q.new_host         <= cmd.new_host;
					res_q.table_full       <= cmd.table_full;
					res_q.byte_total_out   <= '0;
					res_q.packet_total_out <= '0;
				end
			end
			ST_INIT: begin
				res_q.byte_total_out   <= BYTE_W'(cmd_q.ip_length);
				res_q.packet_total_out <= PKT_W'(1);
			end
			ST_UPD: begin
				res_q.byte_total_out   <= new_b;
				res_q.packet_total_out <= new_p;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
